FILE: rtl/cpf_pkg.sv
// shared types, constants and the crc byte update for the packet framer
// no dependencies
package cpf_pkg;

  localparam int unsigned DefFifoDepth = 4;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h8408;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_ERROR
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic        close;
  } cmd_t;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/cpf_front.sv
// front end: accepts input words, tracks the open packet and classifies each word
// depends on cpf_pkg
module cpf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  input  logic [7:0]    in_type_i,
  input  logic [7:0]    in_len_i,
  input  logic [7:0]    in_data_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          q_push_o,
  output cpf_pkg::cmd_t q_cmd_o
);
  import cpf_pkg::*;

  logic       open_q, open_d;
  logic [7:0] rem_q, rem_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    open_d  = open_q;
    rem_d   = rem_q;
    q_cmd_o = '{kind: CMD_ERROR, byte_a: 8'h00, byte_b: 8'h00, close: 1'b0};
    if (!in_op_i) begin
      q_cmd_o = '{kind: CMD_START, byte_a: in_type_i, byte_b: in_len_i,
                  close: (in_len_i == 8'h00)};
      if (accept) begin
        open_d = (in_len_i != 8'h00);
        rem_d  = in_len_i;
      end
    end else if (open_q) begin
      q_cmd_o = '{kind: CMD_DATA, byte_a: in_data_i, byte_b: 8'h00,
                  close: (rem_q == 8'h01)};
      if (accept) begin
        rem_d  = rem_q - 8'h01;
        open_d = (rem_q != 8'h01);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= 8'h00;
    end else begin
      open_q <= open_d;
      rem_q  <= rem_d;
    end
  end

  a_open_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (rem_q != 8'h00))
    else $error("packet open flag disagrees with remaining count");

endmodule

FILE: rtl/cpf_fifo.sv
// short command queue between the front end and the byte emitter
// depends on cpf_pkg
module cpf_fifo #(
  parameter int unsigned Depth = cpf_pkg::DefFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cpf_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cpf_pkg::cmd_t head_o
);
  import cpf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pointers_track_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

FILE: rtl/cpf_back.sv
// back end: expands queued commands into bytes, runs the crc, holds the output word
// depends on cpf_pkg
module cpf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  cpf_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_err_o
);
  import cpf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic        valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        err_q, err_d;
  logic        adv, emit;

  assign adv  = !valid_q || out_ready_i;
  assign emit = adv && q_valid_i;

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    byte_d  = 8'h00;
    last_d  = 1'b0;
    err_d   = 1'b0;
    q_pop_o = 1'b0;
    if (emit) begin
      unique case (phase_q)
        PH_FIRST: begin
          unique case (q_cmd_i.kind)
            CMD_START: begin
              byte_d  = q_cmd_i.byte_a;
              crc_d   = crc16_feed(CrcInit, q_cmd_i.byte_a);
              phase_d = PH_SECOND;
            end
            CMD_DATA: begin
              byte_d = q_cmd_i.byte_a;
              crc_d  = crc16_feed(crc_q, q_cmd_i.byte_a);
              if (q_cmd_i.close) begin
                phase_d = PH_CRC_LO;
              end else begin
                q_pop_o = 1'b1;
              end
            end
            default: begin
              err_d   = 1'b1;
              q_pop_o = 1'b1;
            end
          endcase
        end
        PH_SECOND: begin
          byte_d = q_cmd_i.byte_b;
          crc_d  = crc16_feed(crc_q, q_cmd_i.byte_b);
          if (q_cmd_i.close) begin
            phase_d = PH_CRC_LO;
          end else begin
            phase_d = PH_FIRST;
            q_pop_o = 1'b1;
          end
        end
        PH_CRC_LO: begin
          byte_d  = ~crc_q[7:0];
          phase_d = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          byte_d  = ~crc_q[15:8];
          last_d  = 1'b1;
          phase_d = PH_FIRST;
          q_pop_o = 1'b1;
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      crc_q   <= CrcInit;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      if (adv) begin
        valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

  a_last_not_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |-> !err_q)
    else $error("crc high byte flagged as error");

  a_error_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && err_q |-> (byte_q == 8'h00))
    else $error("error word with nonzero byte");

endmodule

FILE: rtl/crc16_packet_framer.sv
// top level of the crc-16 packet framer: front end, command queue, byte emitter
// depends on cpf_pkg, cpf_front, cpf_fifo, cpf_back
//
//   channel  dir  tdata                                     tuser  tlast
//   s_axis   in   [7:0] type, [15:8] length, [23:16] data   op     -
//   m_axis   out  [7:0] byte                                error  crc high byte
//
// one input word is taken per cycle while the command queue has room
// the emitter sends one byte per cycle unless stalled: start 2 bytes (4 with zero length),
// payload 1 byte (3 on the last one), error 1 word; the queue absorbs the bursts
// a stalled output holds its word while the front end keeps filling the queue
// reset clears packet state, queue pointers and the crc; no clearing pass
module crc16_packet_framer #(
  parameter int unsigned FifoDepth = cpf_pkg::DefFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] pkt_type, [15:8] payload_length, [23:16] data_byte
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] error
);
  import cpf_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, full, pop, head_valid;

  cpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_type_i  (s_axis_tdata[7:0]),
    .in_len_i   (s_axis_tdata[15:8]),
    .in_data_i  (s_axis_tdata[23:16]),
    .q_full_i   (full),
    .in_ready_o (s_axis_tready),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  cpf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_cmd)
  );

  cpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (head_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule
